/* hw/rtl/lecc_pkg.sv */
package lecc_pkg;

	// break characters
	localparam logic [7:0] BYTE_LF = 8'h0A;
	localparam logic [7:0] BYTE_CR = 8'h0D;

	typedef logic [1:0]  held_t;
	typedef logic [2:0]  brk_t;
	typedef logic [1:0]  status_t;
	typedef logic [31:0] line_t;

	// pending break byte
	localparam held_t HELD_NONE = 2'd0;
	localparam held_t HELD_CR   = 2'd1;
	localparam held_t HELD_LF   = 2'd2;

	// break types, also the codes of valid_ending
	localparam brk_t TYPE_NONE = 3'd0;
	localparam brk_t TYPE_CR   = 3'd1;
	localparam brk_t TYPE_LF   = 3'd2;
	localparam brk_t TYPE_CRLF = 3'd3;
	localparam brk_t TYPE_LFCR = 3'd4;

	localparam status_t ST_OK           = 2'd0;
	localparam status_t ST_INVALID      = 2'd1;
	localparam status_t ST_INCONSISTENT = 2'd2;

	localparam line_t LINE_FIRST = 32'd1;
	localparam line_t LINE_MAX   = 32'hFFFF_FFFF;

	typedef struct packed {
		held_t   held;
		brk_t    locked;
		line_t   line;
		status_t verdict;
		line_t   vline;
	} stream_state_t;

	localparam stream_state_t STATE_CLEAR = '{
		held:    HELD_NONE,
		locked:  TYPE_NONE,
		line:    LINE_FIRST,
		verdict: ST_OK,
		vline:   LINE_FIRST
	};

	typedef struct packed {
		status_t status;
		line_t   error_line;
		brk_t    detected_ending;
	} result_t;

endpackage

/* hw/rtl/lecc_if.sv */
interface lecc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lecc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] error_line;
	logic [2:0]  detected_ending;

	modport source (output valid, output status, output error_line, output detected_ending,
		input ready);
	modport sink   (input valid, input status, input error_line, input detected_ending,
		output ready);
endinterface

/* hw/rtl/line_ending_consistency_checker.sv */
// Channel | Dir | Payload                                  | Accepted when
// stream  | in  | data_byte[7:0], last_byte                | valid && ready
// result  | out | status[1:0], error_line[31:0], det.[2:0] | valid && ready
// config  | in  | valid_ending_wdata[2:0]                  | valid_ending_we
//
// One byte per cycle, except while a verdict is held that the sink is not taking.
// A verdict appears in the output register the cycle after its last byte.
// The stream state sits in registers updated at each accepted item; the
// per-byte logic is one compare stage and two chained 32-bit increments.
// Result register parts the two sides: stream ready drops only while a verdict
// is held and the sink is not taking it.
// arst_n clears the stream state, the result valid flag and valid_ending.
module line_ending_consistency_checker import lecc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	lecc_in_if.sink          stream,
	lecc_out_if.source       result,
	input  logic             valid_ending_we,
	input  logic [2:0]       valid_ending_wdata
);

	brk_t          valid_ending_q;
	stream_state_t state_q;
	stream_state_t state_next;
	result_t       res_next;
	result_t       res_q;
	logic          out_valid_q;
	logic          accept;

	// Required type; codes above LFCR match nothing, so the first break fails.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_ending_q <= TYPE_NONE;
		else if (valid_ending_we) valid_ending_q <= valid_ending_wdata;
	end

	lecc_step u_step (
		.state        (state_q),
		.data_byte    (stream.data_byte),
		.last_byte    (stream.last_byte),
		.valid_ending (valid_ending_q),
		.state_next   (state_next),
		.result       (res_next)
	);

	// stall only when a finished verdict is still waiting
	assign stream.ready = !out_valid_q || result.ready;
	assign accept       = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (accept) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && stream.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload only; no reset
	always_ff @(posedge clk) begin
		if (accept && stream.last_byte) res_q <= res_next;
	end

	assign result.valid           = out_valid_q;
	assign result.status          = res_q.status;
	assign result.error_line      = res_q.error_line;
	assign result.detected_ending = res_q.detected_ending;

	// a fresh verdict only follows the last byte of a stream
	a_verdict_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(accept && stream.last_byte))
		else $error("verdict without last byte");

	// an error always has a locked break type behind it
	a_error_locked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.verdict != ST_OK |-> state_q.locked != TYPE_NONE)
		else $error("error with no locked type");

	// line counters never wrap to zero
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line != '0 && state_q.vline != '0)
		else $error("line counter at zero");

	// once an error is recorded, the stream state stays put until the last byte
	a_error_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !stream.last_byte && state_q.verdict != ST_OK) |=>
		$stable(state_q))
		else $error("state moved after error");

endmodule

/* hw/rtl/lecc_step.sv */
// One byte of stream state update, pure logic.
module lecc_step import lecc_pkg::*; (
	input  stream_state_t state,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  brk_t          valid_ending,
	output stream_state_t state_next,
	output result_t       result
);

	function automatic stream_state_t take_break(stream_state_t s, brk_t kind, brk_t req);
		stream_state_t r;
		logic          err;
		r   = s;
		err = 1'b0;
		if (r.verdict == ST_OK) begin
			if (r.locked == TYPE_NONE) begin
				r.locked = kind;
				if (req != TYPE_NONE && kind != req) begin
					r.verdict = ST_INVALID;
					err       = 1'b1;
				end
			end else if (kind != r.locked) begin
				r.verdict = ST_INCONSISTENT;
				err       = 1'b1;
			end
			if (err) begin
				r.vline = r.line;
			end else if (r.line != LINE_MAX) begin
				r.line = r.line + LINE_FIRST;
			end
		end
		return r;
	endfunction

	stream_state_t s;
	brk_t          kind;
	held_t         nh;

	always_comb begin
		s    = state;
		kind = TYPE_NONE;
		nh   = HELD_NONE;
		if (state.verdict == ST_OK) begin
			case (state.held)
				HELD_CR: begin
					if (data_byte == BYTE_LF) begin
						kind = TYPE_CRLF;
					end else begin
						kind = TYPE_CR;
						if (data_byte == BYTE_CR) nh = HELD_CR;
					end
				end
				HELD_LF: begin
					if (data_byte == BYTE_CR) begin
						kind = TYPE_LFCR;
					end else begin
						kind = TYPE_LF;
						if (data_byte == BYTE_LF) nh = HELD_LF;
					end
				end
				default: begin
					if (data_byte == BYTE_CR)      nh = HELD_CR;
					else if (data_byte == BYTE_LF) nh = HELD_LF;
				end
			endcase
			s.held = nh;
			if (kind != TYPE_NONE) s = take_break(s, kind, valid_ending);
			// break byte left pending at end of stream counts alone
			if (last_byte && s.held != HELD_NONE) begin
				s      = take_break(s, (s.held == HELD_CR) ? TYPE_CR : TYPE_LF, valid_ending);
				s.held = HELD_NONE;
			end
		end
		result.status          = s.verdict;
		result.error_line      = (s.verdict != ST_OK) ? s.vline : s.line;
		result.detected_ending = s.locked;
		state_next             = last_byte ? STATE_CLEAR : s;
	end

endmodule

/* tb/sv/line_ending_consistency_checker_test.sv */
module line_ending_consistency_checker_test;
	import lecc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Top of the register code space; 5 to 7 name no break type at all.
	localparam brk_t CODE_UNUSED_TOP = 3'd7;

	logic clk;
	logic arst_n;
	logic valid_ending_we;
	logic [2:0] valid_ending_wdata;

	lecc_in_if  byte_ch ();
	lecc_out_if verdict_ch ();

	line_ending_consistency_checker uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.stream             (byte_ch),
		.result             (verdict_ch),
		.valid_ending_we    (valid_ending_we),
		.valid_ending_wdata (valid_ending_wdata)
	);

	// 4 ns period, low phase first so the first real edge is a rising one.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Idle percentages, changed per phase by the stimulus process.
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;

	int errors        = 0;
	int bytes_sent    = 0;
	int scanned_bytes = 0;
	int verdicts_seen = 0;
	int cfg_writes    = 0;

	// Verdicts still owed by the block, oldest first.
	result_t pending_verdicts[$];

	// Bytes of the next random stream.
	logic [7:0] stream_bytes[$];

	// ------------------------------------------------------------------
	// Line-ending predictor: its own copy of the stream state and of the
	// required break type.
	// ------------------------------------------------------------------
	brk_t    required_ending;
	held_t   pend_brk;
	brk_t    lock_kind;
	line_t   cur_line;
	status_t verdict_st;
	line_t   verdict_at;

	function automatic void clear_stream();
		pend_brk   = HELD_NONE;
		lock_kind  = TYPE_NONE;
		cur_line   = LINE_FIRST;
		verdict_st = ST_OK;
		verdict_at = LINE_FIRST;
	endfunction

	// One complete break: lock on the first, compare the rest.
	function automatic void note_break(input brk_t kind);
		if (verdict_st != ST_OK)
			return;
		if (lock_kind == TYPE_NONE) begin
			lock_kind = kind;
			if (required_ending != TYPE_NONE && kind != required_ending) begin
				verdict_st = ST_INVALID;
				verdict_at = cur_line;
				return;
			end
		end else if (kind != lock_kind) begin
			verdict_st = ST_INCONSISTENT;
			verdict_at = cur_line;
			return;
		end
		if (cur_line != LINE_MAX)
			cur_line++;
	endfunction

	// Advances the predictor by one accepted byte; returns 1 with the
	// verdict when the byte closes the stream.
	function automatic bit scan_byte(input logic [7:0] data, input logic last,
		output result_t verdict);
		held_t nxt;
		brk_t  kind;
		nxt     = HELD_NONE;
		kind    = TYPE_NONE;
		verdict = '0;
		if (verdict_st == ST_OK) begin
			scanned_bytes++;
			case (pend_brk)
				HELD_CR: begin
					if (data == BYTE_LF) begin
						kind = TYPE_CRLF;
					end else begin
						kind = TYPE_CR;
						if (data == BYTE_CR)
							nxt = HELD_CR;
					end
				end
				HELD_LF: begin
					if (data == BYTE_CR) begin
						kind = TYPE_LFCR;
					end else begin
						kind = TYPE_LF;
						if (data == BYTE_LF)
							nxt = HELD_LF;
					end
				end
				default: begin
					if (data == BYTE_CR)
						nxt = HELD_CR;
					else if (data == BYTE_LF)
						nxt = HELD_LF;
				end
			endcase
			pend_brk = nxt;
			if (kind != TYPE_NONE)
				note_break(kind);
			// a break byte still pending at the end counts on its own
			if (last && pend_brk != HELD_NONE) begin
				note_break(pend_brk == HELD_CR ? TYPE_CR : TYPE_LF);
				pend_brk = HELD_NONE;
			end
		end
		if (!last)
			return 1'b0;
		verdict.status          = verdict_st;
		verdict.error_line      = (verdict_st != ST_OK) ? verdict_at : cur_line;
		verdict.detected_ending = lock_kind;
		clear_stream();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Directed table. Verdicts that are plain to see are typed in; the
	// rest (want left at zero, typed clear) come from the predictor.
	// ------------------------------------------------------------------
	typedef struct {
		bit         wr;
		brk_t       code;
		logic [7:0] data;
		bit         last;
		bit         typed;
		result_t    want;
	} dir_row_t;

	dir_row_t dir_rows [0:25] = '{
		// lone NUL straight after reset, then the top byte value
		'{1'b1, TYPE_NONE, 8'h00, 1'b1, 1'b1, '{ST_OK, LINE_FIRST, TYPE_NONE}},
		'{1'b0, TYPE_NONE, 8'hFF, 1'b1, 1'b1, '{ST_OK, LINE_FIRST, TYPE_NONE}},
		// CR as the last byte breaks on its own
		'{1'b0, TYPE_NONE, BYTE_CR, 1'b1, 1'b1, '{ST_OK, 32'd2, TYPE_CR}},
		// final CR closes one CR break and opens another
		'{1'b0, TYPE_NONE, BYTE_CR, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_CR, 1'b1, 1'b1, '{ST_OK, 32'd3, TYPE_CR}},
		// LFCR pair ending the stream
		'{1'b0, TYPE_NONE, BYTE_LF, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_CR, 1'b1, 1'b1, '{ST_OK, 32'd2, TYPE_LFCR}},
		// CR then NUL is a lone CR; trailing LF clashes with it
		'{1'b0, TYPE_NONE, BYTE_CR, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, 8'h00, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_LF, 1'b1, 1'b1, '{ST_INCONSISTENT, 32'd2, TYPE_CR}},
		// CRLF then LFCR: error, then bytes ignored up to the end
		'{1'b0, TYPE_NONE, BYTE_CR, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_LF, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_LF, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_CR, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_CR, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_LF, 1'b1, 1'b0, '0},
		// LF required, CR found
		'{1'b1, TYPE_LF, BYTE_CR, 1'b1, 1'b1, '{ST_INVALID, LINE_FIRST, TYPE_CR}},
		// unused code matches nothing
		'{1'b1, CODE_UNUSED_TOP, BYTE_LF, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, 8'h58, 1'b1, 1'b1, '{ST_INVALID, LINE_FIRST, TYPE_LF}},
		// CRLF required and kept
		'{1'b1, TYPE_CRLF, BYTE_CR, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_LF, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, 8'h7F, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_CR, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_LF, 1'b1, 1'b0, '0},
		// LFCR required and met
		'{1'b1, TYPE_LFCR, BYTE_LF, 1'b0, 1'b0, '0},
		'{1'b0, TYPE_NONE, BYTE_CR, 1'b1, 1'b1, '{ST_OK, 32'd2, TYPE_LFCR}}
	};

	task automatic log_failure(input string msg);
		$display("line_ending_consistency_checker_test: FAIL %0t: %s", $realtime, msg);
		errors++;
	endtask

	// Offers one item at a falling edge, waits for it to be taken and
	// leaves valid high, so back-to-back items need no gap.
	task automatic send_byte(input logic [7:0] data, input logic last, input bit typed,
		input result_t want);
		result_t verdict;
		while ($urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= data;
		byte_ch.last_byte <= last;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		if (scan_byte(data, last, verdict))
			pending_verdicts.push_back(typed ? want : verdict);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Register write with the block idle: every verdict back and the result
	// register empty.
	task automatic write_required_ending(input brk_t code);
		byte_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
		valid_ending_we    <= 1'b1;
		valid_ending_wdata <= code;
		@(negedge clk);
		valid_ending_we <= 1'b0;
		required_ending = code;
		cfg_writes++;
	endtask

	// Filler for a line, any byte but a break byte; NUL now and then.
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		if ($urandom_range(9) == 0)
			return 8'h00;
		do
			b = 8'($urandom_range(0, 255));
		while (b == BYTE_CR || b == BYTE_LF);
		return b;
	endfunction

	// Mostly well-formed streams of one break type, some with one break of a
	// type drawn anew at random; the rest is noise rich in CR and LF.
	task automatic compose_stream();
		brk_t kind;
		brk_t odd_kind;
		int   lines;
		int   bad_line;
		brk_t this_kind;
		stream_bytes.delete();
		if ($urandom_range(99) < 75) begin
			if (required_ending >= TYPE_CR && required_ending <= TYPE_LFCR &&
				$urandom_range(3) != 0)
				kind = required_ending;
			else
				kind = brk_t'($urandom_range(TYPE_CR, TYPE_LFCR));
			odd_kind = brk_t'($urandom_range(TYPE_CR, TYPE_LFCR));
			lines    = $urandom_range(1, 10);
			bad_line = ($urandom_range(4) == 0) ? int'($urandom_range(0, lines - 1)) : -1;
			for (int i = 0; i < lines; i++) begin
				repeat ($urandom_range(0, 4)) stream_bytes.push_back(text_byte());
				this_kind = (i == bad_line) ? odd_kind : kind;
				case (this_kind)
					TYPE_CR:   stream_bytes.push_back(BYTE_CR);
					TYPE_LF:   stream_bytes.push_back(BYTE_LF);
					TYPE_CRLF: begin
						stream_bytes.push_back(BYTE_CR);
						stream_bytes.push_back(BYTE_LF);
					end
					default: begin
						stream_bytes.push_back(BYTE_LF);
						stream_bytes.push_back(BYTE_CR);
					end
				endcase
			end
			// half the streams end on a break byte
			if ($urandom_range(1) != 0)
				repeat ($urandom_range(1, 3)) stream_bytes.push_back(text_byte());
		end else begin
			repeat ($urandom_range(1, 24)) begin
				case ($urandom_range(3))
					0:       stream_bytes.push_back(BYTE_CR);
					1:       stream_bytes.push_back(BYTE_LF);
					default: stream_bytes.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
	endtask

	// Verdict sink: ready changes at falling edges only.
	initial begin
		verdict_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			verdict_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Every verdict taken is matched against the oldest one owed.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				log_failure($sformatf("verdict with none owed: status %0d line %0d type %0d",
					verdict_ch.status, verdict_ch.error_line, verdict_ch.detected_ending));
			end else begin
				want = pending_verdicts.pop_front();
				if (verdict_ch.status !== want.status)
					log_failure($sformatf("status %0d, wanted %0d",
						verdict_ch.status, want.status));
				if (verdict_ch.error_line !== want.error_line)
					log_failure($sformatf("error_line %0d, wanted %0d",
						verdict_ch.error_line, want.error_line));
				if (verdict_ch.detected_ending !== want.detected_ending)
					log_failure($sformatf("detected_ending %0d, wanted %0d",
						verdict_ch.detected_ending, want.detected_ending));
			end
		end
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#2ms;
		$display("line_ending_consistency_checker_test: timed out");
		$display("line_ending_consistency_checker_test: done, errors");
		$finish;
	end

	initial begin
		int phase_target;
		arst_n             = 1'b0;
		byte_ch.valid      = 1'b0;
		byte_ch.data_byte  = '0;
		byte_ch.last_byte  = 1'b0;
		valid_ending_we    = 1'b0;
		valid_ending_wdata = '0;
		required_ending    = TYPE_NONE;
		clear_stream();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: sender and sink both steady
		foreach (dir_rows[i]) begin
			if (dir_rows[i].wr)
				write_required_ending(dir_rows[i].code);
			send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
		end

		// random: nine phases sweep every register code 0..7, then 0 again;
		// three phases each with a slow sink, a slow sender, then neither
		for (int phase = 0; phase < 9; phase++) begin
			write_required_ending(brk_t'(phase % 8));
			case (phase / 3)
				0:       begin src_idle_pct = 6;  sink_idle_pct = 55; end
				1:       begin src_idle_pct = 55; sink_idle_pct = 6;  end
				default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
			endcase
			// every byte fed counts towards the phase, skipped ones too
			phase_target = bytes_sent + 170;
			while (bytes_sent < phase_target) begin
				compose_stream();
				foreach (stream_bytes[k])
					send_byte(stream_bytes[k], k == stream_bytes.size() - 1, 1'b0, '0);
			end
		end

		byte_ch.valid <= 1'b0;
		sink_idle_pct = 0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("line_ending_consistency_checker_test: %0d bytes fed, %0d of them scanned",
			bytes_sent, scanned_bytes);
		$display("line_ending_consistency_checker_test: %0d verdicts checked, %0d register writes",
			verdicts_seen, cfg_writes);
		if (errors == 0)
			$display("line_ending_consistency_checker_test: done, clean");
		else
			$display("line_ending_consistency_checker_test: done, errors");
		$finish;
	end

endmodule
